[src/sps_pkg.sv]
package sps_pkg;

    localparam int NUM_SIGNATURES_DEF  = 16;
    localparam int MAX_PATTERN_LEN_DEF = 32;
    localparam int POSITION_BITS_DEF   = 27;

    localparam int SLOT_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 5;
    localparam int LEN_W    = 6;
    localparam int OFFSET_W = 27;

    typedef enum logic [1:0] {
        OP_SCAN    = 2'd0,
        OP_PATTERN = 2'd1,
        OP_HEADER  = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]          operation;
        logic [BYTE_W-1:0]   byte_value;
        logic                last_byte;
        logic [SLOT_W-1:0]   sig_slot;
        logic [POS_W-1:0]    byte_pos;
        logic [LEN_W-1:0]    pattern_length;
        logic [OFFSET_W-1:0] match_offset;
        logic                search_anywhere;
        logic [BYTE_W-1:0]   severity_in;
    } t_in_item;

    typedef struct packed {
        logic              match_found;
        logic [SLOT_W-1:0] matched_slot;
        logic [BYTE_W-1:0] match_severity;
    } t_out_item;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] severity;
    } t_chain;

endpackage

[src/sps_if.sv]
interface sps_in_if;
    import sps_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sps_out_if;
    import sps_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/sps_window.sv]
module sps_window #(
    parameter int MAX_PATTERN_LEN = sps_pkg::MAX_PATTERN_LEN_DEF,
    parameter int POSITION_BITS   = sps_pkg::POSITION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_shift,
    input  logic                           i_last,
    input  logic [sps_pkg::BYTE_W-1:0]     i_byte,
    output logic [sps_pkg::BYTE_W-1:0]     o_win_n [MAX_PATTERN_LEN],
    output logic [POSITION_BITS-1:0]       o_pos
);
    import sps_pkg::*;

    logic [BYTE_W-1:0]        r_win [MAX_PATTERN_LEN];
    logic [POSITION_BITS-1:0] r_count;
    logic [POSITION_BITS-1:0] n_count;

    always_comb begin
        o_win_n[0] = i_byte;
        for (int j = 1; j < MAX_PATTERN_LEN; j++) begin
            o_win_n[j] = r_win[j-1];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_shift) begin
            if (i_last) begin
                n_count = '0;
            end else if (r_count != '1) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win <= o_win_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_pos = r_count;

endmodule

[src/sps_cell.sv]
module sps_cell #(
    parameter int CELL_IDX        = 0,
    parameter int MAX_PATTERN_LEN = sps_pkg::MAX_PATTERN_LEN_DEF,
    parameter int POSITION_BITS   = sps_pkg::POSITION_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  sps_pkg::t_in_item          i_item,
    input  logic [sps_pkg::BYTE_W-1:0] i_win_n [MAX_PATTERN_LEN],
    input  logic [POSITION_BITS-1:0]   i_pos,
    input  logic                       i_snap,
    input  sps_pkg::t_chain            i_chain,
    output sps_pkg::t_chain            o_chain
);
    import sps_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN_LEN + 1);
    localparam int PW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

    logic [BYTE_W-1:0]        r_pat [MAX_PATTERN_LEN];
    logic [LW-1:0]            r_len;
    logic [POSITION_BITS-1:0] r_off;
    logic                     r_any;
    logic [BYTE_W-1:0]        r_sev;
    logic                     r_mis;
    logic                     r_hit;
    logic                     r_snap_hit;
    logic [BYTE_W-1:0]        r_snap_sev;

    logic                     n_mis;
    logic                     n_hit;
    logic                     w_sel;
    logic                     w_scan;
    logic [LW-1:0]            w_len_sat;
    logic [LW-1:0]            w_shamt;
    logic [BYTE_W-1:0]        w_stg [LW+1][MAX_PATTERN_LEN];
    logic                     w_any_ok;
    logic                     w_enough;
    logic [POSITION_BITS-1:0] w_diff;
    logic [PW-1:0]            w_k;
    logic                     w_in_rng;
    logic                     w_fix_mis;

    assign w_sel  = (int'(i_item.sig_slot) == CELL_IDX);
    assign w_scan = i_accept && (i_item.operation == OP_SCAN);

    assign w_len_sat = (int'(i_item.pattern_length) > MAX_PATTERN_LEN) ?
                       LW'(MAX_PATTERN_LEN) : LW'(i_item.pattern_length);

    // The pattern is shifted up so that its last byte faces the newest window byte.
    assign w_shamt = LW'(MAX_PATTERN_LEN) - r_len;

    always_comb begin
        w_stg[0] = r_pat;
        for (int s = 0; s < LW; s++) begin
            for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
                if (!w_shamt[s]) begin
                    w_stg[s+1][k] = w_stg[s][k];
                end else if (k >= (1 << s)) begin
                    w_stg[s+1][k] = w_stg[s][k - (1 << s)];
                end else begin
                    w_stg[s+1][k] = '0;
                end
            end
        end
    end

    always_comb begin
        w_any_ok = 1'b1;
        for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
            if (k >= int'(w_shamt) &&
                w_stg[LW][k] != i_win_n[MAX_PATTERN_LEN-1-k]) begin
                w_any_ok = 1'b0;
            end
        end
    end

    assign w_enough = ((POSITION_BITS+1)'(i_pos) + 1'b1) >= (POSITION_BITS+1)'(r_len);

    assign w_diff   = i_pos - r_off;
    assign w_in_rng = (i_pos >= r_off) && (w_diff < POSITION_BITS'(r_len));
    assign w_k      = w_diff[PW-1:0];

    always_comb begin
        w_fix_mis = 1'b0;
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            if (w_k == PW'(i) && r_pat[i] != i_item.byte_value) begin
                w_fix_mis = 1'b1;
            end
        end
    end

    always_comb begin
        n_hit = r_hit;
        n_mis = r_mis;
        if (w_scan && r_len != '0) begin
            if (r_any) begin
                if (w_enough && w_any_ok) begin
                    n_hit = 1'b1;
                end
            end else if (i_pos != '1 && w_in_rng) begin
                if (w_fix_mis) begin
                    n_mis = 1'b1;
                end
                if (w_diff == POSITION_BITS'(r_len) - 1'b1 && !n_mis) begin
                    n_hit = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && w_sel && i_item.operation == OP_PATTERN) begin
            for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
                if (int'(i_item.byte_pos) == i) begin
                    r_pat[i] <= i_item.byte_value;
                end
            end
        end
        if (i_snap) begin
            r_snap_sev <= r_sev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_off      <= '0;
            r_any      <= 1'b0;
            r_sev      <= '0;
            r_mis      <= 1'b0;
            r_hit      <= 1'b0;
            r_snap_hit <= 1'b0;
        end else begin
            if (i_accept && w_sel) begin
                case (i_item.operation)
                    OP_HEADER: begin
                        r_len <= w_len_sat;
                        r_off <= POSITION_BITS'(i_item.match_offset);
                        r_any <= i_item.search_anywhere;
                        r_sev <= i_item.severity_in;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_snap) begin
                r_snap_hit <= n_hit;
                r_hit      <= 1'b0;
                r_mis      <= 1'b0;
            end else begin
                r_hit <= n_hit;
                r_mis <= n_mis;
            end
        end
    end

    always_comb begin
        if (i_chain.found) begin
            o_chain = i_chain;
        end else if (r_snap_hit) begin
            o_chain.found    = 1'b1;
            o_chain.slot     = SLOT_W'(CELL_IDX);
            o_chain.severity = r_snap_sev;
        end else begin
            o_chain = '0;
        end
    end

endmodule

[src/signature_pattern_scanner_unit.sv]
// Signature scanner: a file streams in one byte per transfer, one transfer per cycle while
// ready is high, and is checked against every table entry at once by a row of signature
// cells, one per entry, that share a history window of the newest bytes. Pattern and header
// loads are transfers on the same channel and take effect from the next byte. The byte
// marked last produces one result, held in the cells' snapshot registers, then in the output
// register; the lowest matching entry is picked by a priority chain through the cells. Input
// is held off only in reset or while a result waits there with a second captured behind it.
module signature_pattern_scanner_unit #(
    parameter int NUM_SIGNATURES  = sps_pkg::NUM_SIGNATURES_DEF,
    parameter int MAX_PATTERN_LEN = sps_pkg::MAX_PATTERN_LEN_DEF,
    parameter int POSITION_BITS   = sps_pkg::POSITION_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sps_in_if.sink    i_in,
    sps_out_if.source o_out
);
    import sps_pkg::*;

    logic                     w_accept;
    logic                     w_scan;
    logic                     w_snap;
    logic                     w_out_free;
    logic                     w_move;
    logic [BYTE_W-1:0]        w_win_n [MAX_PATTERN_LEN];
    logic [POSITION_BITS-1:0] w_pos;
    t_chain                   w_chain [NUM_SIGNATURES+1];

    logic                     r_snap_valid;
    logic                     r_out_valid;
    t_out_item                r_out;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_move     = r_snap_valid && w_out_free;
    assign i_in.ready = i_rst_n && (!r_snap_valid || w_out_free);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_scan     = w_accept && (i_in.data.operation == OP_SCAN);
    assign w_snap     = w_scan && i_in.data.last_byte;

    sps_window #(
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .POSITION_BITS   (POSITION_BITS)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_scan),
        .i_last  (i_in.data.last_byte),
        .i_byte  (i_in.data.byte_value),
        .o_win_n (w_win_n),
        .o_pos   (w_pos)
    );

    assign w_chain[0] = '0;

    for (genvar g = 0; g < NUM_SIGNATURES; g++) begin : g_cell
        sps_cell #(
            .CELL_IDX        (g),
            .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
            .POSITION_BITS   (POSITION_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (w_accept),
            .i_item   (i_in.data),
            .i_win_n  (w_win_n),
            .i_pos    (w_pos),
            .i_snap   (w_snap),
            .i_chain  (w_chain[g]),
            .o_chain  (w_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out.match_found    <= w_chain[NUM_SIGNATURES].found;
            r_out.matched_slot   <= w_chain[NUM_SIGNATURES].slot;
            r_out.match_severity <= w_chain[NUM_SIGNATURES].severity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_snap_valid <= w_snap || (r_snap_valid && !w_out_free);
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

[tb/sv/tb_signature_pattern_scanner_unit.sv]
module tb_signature_pattern_scanner_unit;
    import sps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSIG      = NUM_SIGNATURES_DEF;
    localparam int PLEN      = MAX_PATTERN_LEN_DEF;
    localparam int CYCLE_CAP = 400000;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    class sps_scoreboard;
        logic [BYTE_W-1:0]   pat [NSIG][PLEN];
        int unsigned         plen [NSIG];
        logic [OFFSET_W-1:0] foff [NSIG];
        bit                  anyw [NSIG];
        logic [BYTE_W-1:0]   sev [NSIG];
        logic [BYTE_W-1:0]   hist [PLEN];
        logic [OFFSET_W-1:0] file_pos;
        bit                  miss [NSIG];
        bit                  hit [NSIG];
        t_out_item           verdicts [$];
        int                  errors;

        function new();
            errors = 0;
            file_pos = '0;
            for (int s = 0; s < NSIG; s++) begin
                plen[s] = 0;
                foff[s] = '0;
                anyw[s] = 1'b0;
                sev[s]  = '0;
                miss[s] = 1'b0;
                hit[s]  = 1'b0;
                for (int i = 0; i < PLEN; i++) pat[s][i] = '0;
            end
            for (int i = 0; i < PLEN; i++) hist[i] = '0;
        endfunction

        function void scan_byte(logic [BYTE_W-1:0] b);
            longint unsigned p;
            longint unsigned len;
            longint unsigned k;
            bit fixed_ok;
            bit ok;
            p = file_pos;
            fixed_ok = (file_pos != {OFFSET_W{1'b1}});
            for (int i = PLEN - 1; i > 0; i--) hist[i] = hist[i-1];
            hist[0] = b;
            for (int s = 0; s < NSIG; s++) begin
                len = plen[s];
                if (len == 0) continue;
                if (anyw[s]) begin
                    if (p + 1 >= len) begin
                        ok = 1'b1;
                        for (int i = 0; i < len; i++)
                            if (pat[s][i] !== hist[len-1-i]) ok = 1'b0;
                        if (ok) hit[s] = 1'b1;
                    end
                end else if (fixed_ok) begin
                    if (p >= foff[s] && p - foff[s] < len) begin
                        k = p - foff[s];
                        if (pat[s][k] !== b) miss[s] = 1'b1;
                        if (k == len - 1 && !miss[s]) hit[s] = 1'b1;
                    end
                end
            end
            if (fixed_ok) file_pos = file_pos + 1'b1;
        endfunction

        function void note_input(t_in_item it);
            t_out_item v;
            case (it.operation)
                OP_PATTERN: pat[it.sig_slot][it.byte_pos] = it.byte_value;
                OP_HEADER: begin
                    plen[it.sig_slot] = (it.pattern_length > PLEN) ? PLEN : it.pattern_length;
                    foff[it.sig_slot] = it.match_offset;
                    anyw[it.sig_slot] = it.search_anywhere;
                    sev[it.sig_slot]  = it.severity_in;
                end
                OP_SCAN: begin
                    scan_byte(it.byte_value);
                    if (it.last_byte) begin
                        v = '0;
                        for (int s = NSIG - 1; s >= 0; s--) begin
                            if (hit[s]) begin
                                v.match_found    = 1'b1;
                                v.matched_slot   = s[SLOT_W-1:0];
                                v.match_severity = sev[s];
                            end
                        end
                        verdicts = {verdicts, v};
                        file_pos = '0;
                        for (int s = 0; s < NSIG; s++) begin
                            miss[s] = 1'b0;
                            hit[s]  = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = verdicts.pop_front();
            if (got.match_found !== want.match_found) begin
                $display("%0t: match_found expected %0d actual %0d",
                         $time, want.match_found, got.match_found);
                errors++;
            end
            if (got.matched_slot !== want.matched_slot) begin
                $display("%0t: matched_slot expected %0d actual %0d",
                         $time, want.matched_slot, got.matched_slot);
                errors++;
            end
            if (got.match_severity !== want.match_severity) begin
                $display("%0t: match_severity expected %0d actual %0d",
                         $time, want.match_severity, got.match_severity);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    sps_in_if  in_if ();
    sps_out_if out_if ();

    signature_pattern_scanner_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    sps_scoreboard sb = new();
    bit  gaps_on = 1'b1;
    bit  hold_go = 1'b0;
    int  cycles = 0;
    int  sent = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tb_signature_pattern_scanner_unit: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
    end

    initial begin
        int hold_left;
        hold_left = 0;
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= gaps_on ? ($urandom_range(99) >= 11) : 1'b1;
            end
        end
    end

    function automatic t_in_item rnd_item();
        t_in_item it;
        it.operation       = 2'($urandom_range(3));
        it.byte_value      = 8'($urandom);
        it.last_byte       = 1'($urandom);
        it.sig_slot        = 4'($urandom);
        it.byte_pos        = 5'($urandom);
        it.pattern_length  = 6'($urandom);
        it.match_offset    = 27'($urandom);
        it.search_anywhere = 1'($urandom);
        it.severity_in     = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item scan_item(logic [7:0] b, bit last);
        t_in_item it;
        it = rnd_item();
        it.operation  = OP_SCAN;
        it.byte_value = b;
        it.last_byte  = last;
        return it;
    endfunction

    function automatic t_in_item pattern_item(int s, int i, logic [7:0] b);
        t_in_item it;
        it = rnd_item();
        it.operation  = OP_PATTERN;
        it.sig_slot   = SLOT_W'(s);
        it.byte_pos   = POS_W'(i);
        it.byte_value = b;
        return it;
    endfunction

    function automatic t_in_item header_item(int s, int len, logic [26:0] off, bit any,
                                             logic [7:0] sv);
        t_in_item it;
        it = rnd_item();
        it.operation       = OP_HEADER;
        it.sig_slot        = SLOT_W'(s);
        it.pattern_length  = LEN_W'(len);
        it.match_offset    = off;
        it.search_anywhere = any;
        it.severity_in     = sv;
        return it;
    endfunction

    task automatic push_item(input t_in_item it);
        if (gaps_on && $urandom_range(99) < 11) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_input(it);
        sent++;
    endtask

    task automatic push_file();
        logic [7:0] fb [$];
        int flen;
        int t;
        int len;
        int at;
        flen = ($urandom_range(9) == 0) ? $urandom_range(33, 80) : $urandom_range(1, 24);
        for (int i = 0; i < flen; i++)
            fb = {fb, (($urandom_range(3) == 0) ? 8'($urandom_range(1)) : 8'($urandom))};
        if ($urandom_range(99) < 75) begin
            t = $urandom_range(NSIG - 1);
            len = sb.plen[t];
            if (len > 0 && len <= flen) begin
                at = sb.anyw[t] ? $urandom_range(flen - len) : int'(sb.foff[t]);
                if (at + len <= flen)
                    for (int i = 0; i < len; i++) fb[at+i] = sb.pat[t][i];
                if ($urandom_range(5) == 0) fb[$urandom_range(flen - 1)] ^= 8'h01;
            end
        end
        for (int i = 0; i < flen; i++) push_item(scan_item(fb[i], i == flen - 1));
    endtask

    task automatic push_random_header();
        int len;
        logic [26:0] off;
        len = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(0, 8);
        off = ($urandom_range(7) == 0) ? 27'($urandom) : 27'($urandom_range(20));
        push_item(header_item($urandom_range(NSIG - 1), len, off, 1'($urandom),
                              8'($urandom)));
    endtask

    initial begin
        bit pressed;
        int pick;
        t_in_item it;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int s = 0; s < NSIG; s++)
            for (int i = 0; i < PLEN; i++) push_item(pattern_item(s, i, 8'($urandom)));

        push_item(pattern_item(0, 0, 8'hAA));
        push_item(pattern_item(0, 1, 8'hBB));
        push_item(pattern_item(0, 2, 8'hCC));
        push_item(pattern_item(2, 0, 8'hFF));
        push_item(header_item(0, 3, 27'd0, 1'b1, 8'hFF));
        push_item(header_item(1, 0, 27'd0, 1'b0, 8'h11));
        push_item(header_item(2, 1, 27'd0, 1'b0, 8'h00));
        push_item(header_item(15, 63, 27'h7FFFFFF, 1'b0, 8'h80));
        push_item(header_item(5, 32, 27'd0, 1'b1, 8'h55));
        push_item(scan_item(8'hFF, 1'b1));
        push_item(scan_item(8'h00, 1'b1));
        push_item(scan_item(8'hAA, 1'b0));
        push_item(scan_item(8'hBB, 1'b0));
        it = rnd_item();
        it.operation = OP_IGNORED;
        it.last_byte = 1'b1;
        push_item(it);
        it = pattern_item(9, 31, 8'h3C);
        it.last_byte = 1'b1;
        push_item(it);
        push_item(scan_item(8'hCC, 1'b1));
        push_item(scan_item(8'h01, 1'b0));
        push_item(scan_item(8'h00, 1'b1));

        pressed = 1'b0;
        while (sent < 1900) begin
            gaps_on = !(sent > 600 && sent < 900);
            if (!pressed && sent > 1200) begin
                pressed = 1'b1;
                hold_go = 1'b1;
                for (int i = 0; i < 40; i++) push_item(scan_item(8'($urandom), 1'b1));
            end
            pick = $urandom_range(99);
            if (pick < 78) begin
                push_file();
            end else if (pick < 86) begin
                push_random_header();
            end else if (pick < 94) begin
                push_item(pattern_item($urandom_range(NSIG - 1), $urandom_range(PLEN - 1),
                                       8'($urandom)));
            end else begin
                it = rnd_item();
                it.operation = OP_IGNORED;
                push_item(it);
            end
        end
        gaps_on = 1'b1;
        @(negedge i_clk);
        in_if.valid <= 1'b0;

        while (sb.verdicts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_signature_pattern_scanner_unit: PASS");
        end else begin
            $display("tb_signature_pattern_scanner_unit: FAIL");
        end
        $finish;
    end
endmodule
